### hw/rtl/lprp_pkg.sv
// lprp_pkg: shared types and constants of the length-prefixed record parser
// used by the front classifier, the request queue and the back parser
package lprp_pkg;

   // ascii codes seen by the classifier
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_TAB   = 8'h09;
   localparam logic [7:0] ASCII_CR    = 8'h0D;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;
   localparam logic [7:0] ASCII_PLUS  = 8'h2B;

   // parser limits
   localparam logic [1:0]  HEADER_DIGITS    = 2'd3;
   localparam logic [2:0]  ID_FIELD         = 3'd4;
   localparam logic [2:0]  READ_LAST_FIELD  = 3'd4;
   localparam logic [2:0]  WRITE_LAST_FIELD = 3'd5;
   localparam logic [30:0] ID_MAX           = 31'h7FFF_FFFF;
   localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

   // request queue depth default
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   // kind of a result byte
   typedef enum logic [1:0] {
      KIND_LENGTH  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_IGNORED = 2'd2
   } byte_kind_type;

   // progress of the parameter id field
   typedef enum logic [1:0] {
      ID_NONE   = 2'd0,
      ID_DIGITS = 2'd1,
      ID_DONE   = 2'd2,
      ID_NEG    = 2'd3
   } id_state_type;

   // classified request as it travels from front to back
   typedef struct packed {
      logic       start;
      logic [7:0] data;
      logic       is_digit;
      logic [3:0] digit_val;
      logic       is_space;
      logic       is_minus;
      logic       is_plus;
   } entry_type;

endpackage

### hw/rtl/lprp_front.sv
// lprp_front: takes requests from the input channel and classifies each byte
// depends on lprp_pkg for the entry type and ascii codes
module lprp_front (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tuser,
   input  logic               queue_ready,
   output logic               queue_push,
   output lprp_pkg::entry_type queue_entry
);
   import lprp_pkg::*;

   logic [7:0] sub_zero;

   // handshake follows queue space
   assign req_tready = queue_ready;
   assign queue_push = req_tvalid & queue_ready;

   // byte classification
   assign sub_zero = req_tdata - ASCII_ZERO;

   always_comb begin
      queue_entry.start     = req_tuser;
      queue_entry.data      = req_tdata;
      queue_entry.is_digit  = (req_tdata >= ASCII_ZERO) && (req_tdata <= ASCII_NINE);
      queue_entry.digit_val = sub_zero[3:0];
      queue_entry.is_space  = (req_tdata == ASCII_SPACE) ||
                              ((req_tdata >= ASCII_TAB) && (req_tdata <= ASCII_CR));
      queue_entry.is_minus  = (req_tdata == ASCII_MINUS);
      queue_entry.is_plus   = (req_tdata == ASCII_PLUS);
   end

endmodule

### hw/rtl/lprp_queue.sv
// lprp_queue: short fifo of classified requests between front and back
// depends on lprp_pkg for the entry type
module lprp_queue #(
   parameter int QUEUE_DEPTH = lprp_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lprp_pkg::entry_type push_entry,
   output logic                push_ready,
   output logic                pop_valid,
   input  logic                pop,
   output lprp_pkg::entry_type pop_entry
);
   import lprp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/lprp_back.sv
// lprp_back: parser state, mode register and result output register
// depends on lprp_pkg for types and parser constants
module lprp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic                csr_data,
   input  logic                entry_valid,
   input  lprp_pkg::entry_type entry,
   output logic                entry_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);
   import lprp_pkg::*;

   // mode register
   logic read_mode_ff;

   // parser state
   logic         in_payload_ff, in_payload_in;
   logic [1:0]   hdr_seen_ff, hdr_seen_in;
   logic [9:0]   length_left_ff, length_left_in;
   logic [2:0]   field_pos_ff, field_pos_in;
   logic [15:0]  rec_count_ff, rec_count_in;
   logic [30:0]  id_acc_ff, id_acc_in;
   id_state_type id_state_ff, id_state_in;
   logic         halted_ff, halted_in;

   // result register
   logic          out_valid_ff;
   byte_kind_type kind_ff, kind_in;
   logic [7:0]    pay_ff, pay_in;
   logic [2:0]    fnum_ff, fnum_in;
   logic          fend_ff, fend_in;
   logic          rend_ff, rend_in;
   logic          stop_ff, stop_in;
   logic [30:0]   pid_ff, pid_in;

   logic        finish;
   logic        id_field;
   logic [2:0]  last_field;
   logic [34:0] id_mul;
   logic [9:0]  len_mul;
   logic [30:0] count_plus;

   assign entry_pop = entry_valid & (~out_valid_ff | rsp_tready);

   // mode register; the user must write it only while idle, the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         read_mode_ff <= 1'b1;
      end else if (csr_valid) begin
         read_mode_ff <= csr_data;
      end
   end

   // next parser state and result for the entry at the head of the queue
   always_comb begin
      in_payload_in  = entry.start ? 1'b0 : in_payload_ff;
      hdr_seen_in    = entry.start ? '0 : hdr_seen_ff;
      length_left_in = entry.start ? '0 : length_left_ff;
      field_pos_in   = entry.start ? '0 : field_pos_ff;
      rec_count_in   = entry.start ? '0 : rec_count_ff;
      id_acc_in      = entry.start ? '0 : id_acc_ff;
      id_state_in    = entry.start ? ID_NONE : id_state_ff;
      halted_in      = entry.start ? 1'b0 : halted_ff;

      kind_in    = KIND_IGNORED;
      pay_in     = '0;
      fnum_in    = field_pos_in;
      fend_in    = 1'b0;
      rend_in    = 1'b0;
      stop_in    = 1'b0;
      pid_in     = '0;
      finish     = 1'b0;
      id_field   = read_mode_ff && (field_pos_in >= ID_FIELD);
      last_field = read_mode_ff ? READ_LAST_FIELD : WRITE_LAST_FIELD;
      len_mul    = 10'({length_left_in, 3'b000}) + 10'({length_left_in, 1'b0});
      id_mul     = {1'b0, id_acc_in, 3'b000} + {3'b000, id_acc_in, 1'b0}
                   + {31'd0, entry.digit_val};
      count_plus = {15'd0, rec_count_in} + 31'd1;

      // length header or payload byte
      if (!halted_in) begin
         if (!in_payload_in) begin
            if (!entry.is_digit) begin
               halted_in = 1'b1;
               stop_in   = 1'b1;
            end else begin
               kind_in        = KIND_LENGTH;
               length_left_in = len_mul + {6'd0, entry.digit_val};
               hdr_seen_in    = hdr_seen_in + 1'b1;
               if (hdr_seen_in == HEADER_DIGITS) begin
                  hdr_seen_in = '0;
                  if (length_left_in == '0) begin
                     finish = 1'b1;
                  end else begin
                     in_payload_in = 1'b1;
                  end
               end
            end
         end else begin
            kind_in = KIND_PAYLOAD;
            pay_in  = entry.data;
            // id field digits, c-style decimal scan
            if (id_field) begin
               priority if (id_state_in == ID_NONE) begin
                  priority if (entry.is_space) begin
                     id_state_in = ID_NONE;
                  end else if (entry.is_minus) begin
                     id_state_in = ID_NEG;
                  end else if (entry.is_plus) begin
                     id_state_in = ID_DIGITS;
                     id_acc_in   = '0;
                  end else if (entry.is_digit) begin
                     id_state_in = ID_DIGITS;
                     id_acc_in   = {27'd0, entry.digit_val};
                  end else begin
                     id_state_in = ID_DONE;
                  end
               end else if (id_state_in == ID_DIGITS) begin
                  if (entry.is_digit) begin
                     id_acc_in = (id_mul > {4'd0, ID_MAX}) ? ID_MAX : id_mul[30:0];
                  end else begin
                     id_state_in = ID_DONE;
                  end
               end else begin
                  id_state_in = id_state_in;
               end
            end
            if (length_left_in != '0) begin
               length_left_in = length_left_in - 1'b1;
            end
            if (length_left_in == '0) begin
               in_payload_in = 1'b0;
               finish        = 1'b1;
            end
         end
      end

      // field completion, record completion or bad id
      if (finish) begin
         fend_in = 1'b1;
         if (id_field && ((id_state_in == ID_NEG) || (id_acc_in == '0))) begin
            halted_in = 1'b1;
            stop_in   = 1'b1;
         end else begin
            if (field_pos_in >= last_field) begin
               pid_in  = read_mode_ff ? id_acc_in : count_plus;
               rend_in = 1'b1;
               if (rec_count_in != COUNT_MAX) begin
                  rec_count_in = rec_count_in + 1'b1;
               end
               field_pos_in = '0;
            end else begin
               field_pos_in = field_pos_in + 1'b1;
            end
            id_acc_in   = '0;
            id_state_in = ID_NONE;
         end
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff  <= 1'b0;
         hdr_seen_ff    <= '0;
         length_left_ff <= '0;
         field_pos_ff   <= '0;
         rec_count_ff   <= '0;
         id_acc_ff      <= '0;
         id_state_ff    <= ID_NONE;
         halted_ff      <= 1'b0;
      end else if (entry_pop) begin
         in_payload_ff  <= in_payload_in;
         hdr_seen_ff    <= hdr_seen_in;
         length_left_ff <= length_left_in;
         field_pos_ff   <= field_pos_in;
         rec_count_ff   <= rec_count_in;
         id_acc_ff      <= id_acc_in;
         id_state_ff    <= id_state_in;
         halted_ff      <= halted_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (entry_pop) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (entry_pop) begin
         kind_ff <= kind_in;
         pay_ff  <= pay_in;
         fnum_ff <= fnum_in;
         fend_ff <= fend_in;
         rend_ff <= rend_in;
         stop_ff <= stop_in;
         pid_ff  <= pid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = rend_ff;
   assign rsp_tdata  = {4'd0, pid_ff, rec_count_ff, stop_ff, fend_ff, fnum_ff, pay_ff};

endmodule

### hw/rtl/length_prefixed_record_parser.sv
// length_prefixed_record_parser: top level of the record parser
// depends on lprp_pkg, lprp_front, lprp_queue and lprp_back
//
// Usage: requests arrive one byte each on the req_ channel; req_tuser set marks
// the first byte of a new request and clears all parser state and the record
// count. Every accepted request gives exactly one result on the rsp_ channel,
// in order, telling whether the byte was a length digit, a payload byte or
// ignored, with field and record boundaries, stop flag, record count and, at
// a record end (rsp_tlast), the parameter id (in write mode, the record count plus one).
// The csr_ channel writes read_mode (1 read, five fields; 0 write, six
// fields); it is always ready and is meant to be written while idle.
// Path: each request is stored in the request queue (two entries by default),
// then the parser stage registers its result in the result register.
// Throughput: one request per cycle while rsp_tready stays high, as the parser
// updates header counter, length counter and id multiply-accumulate together.
// Reset: synchronous; parser state, count and queue clear, read_mode goes to 1.
// Stall: when rsp_tready is low the result register holds, the parser stops
// and the queue fills; req_tready falls once the queue is full.
module length_prefixed_record_parser #(
   parameter int QUEUE_DEPTH = lprp_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // config write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,      // read_mode
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] data_byte
   input  logic        req_tuser,     // [0] start_of_request
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,     // [7:0] payload_byte, [10:8] field_number,
                                      // [11] field_end, [12] stop_here,
                                      // [28:13] records_done, [59:29] parameter_id
   output logic [1:0]  rsp_tuser,     // [1:0] byte_kind
   output logic        rsp_tlast      // record_end
);
   import lprp_pkg::*;

   logic      queue_ready;
   logic      queue_push;
   entry_type push_entry;
   logic      head_valid;
   logic      head_pop;
   entry_type head_entry;

   assign csr_ready = 1'b1;

   // byte classification
   lprp_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_ready (queue_ready),
      .queue_push  (queue_push),
      .queue_entry (push_entry)
   );

   // request queue between front and back
   lprp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .push_ready (queue_ready),
      .pop_valid  (head_valid),
      .pop        (head_pop),
      .pop_entry  (head_entry)
   );

   // parser and result register
   lprp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .entry_valid (head_valid),
      .entry       (head_entry),
      .entry_pop   (head_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

### dv/length_prefixed_record_parser_test.sv
// testbench for length_prefixed_record_parser: byte requests in, one checked result per request
// depends on lprp_pkg and the parser rtl; the checker package below predicts every result

package record_parse_check_pkg;
   import lprp_pkg::*;

   // one predicted parser result
   typedef struct packed {
      byte_kind_type kind;
      logic [7:0]    payload;
      logic [2:0]    field_num;
      logic          field_end;
      logic          record_end;
      logic          stop;
      logic [15:0]   count;
      logic [30:0]   param_id;
   } parse_result_type;

   // parser state mirror plus the queue of results still owed by the block
   class record_parse_board;
      bit               read_mode;
      bit               in_payload;
      logic [1:0]       digits_seen;
      logic [9:0]       length_left;
      logic [2:0]       field_pos;
      logic [15:0]      rec_count;
      logic [30:0]      id_acc;
      id_state_type     id_phase;
      bit               halted;
      parse_result_type expected_results[$];
      int               errors;
      int               parsed;
      int               records;
      int               stops;
      int               checked;

      function new();
         read_mode = 1'b1;
         restart();
      endfunction

      function void restart();
         in_payload  = 1'b0;
         digits_seen = '0;
         length_left = '0;
         field_pos   = '0;
         rec_count   = '0;
         id_acc      = '0;
         id_phase    = ID_NONE;
         halted      = 1'b0;
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= ASCII_ZERO && b <= ASCII_NINE;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // decimal scan of the id payload, saturating
      function void take_id_byte(logic [7:0] b);
         longint unsigned acc_next;
         case (id_phase)
            ID_NONE: begin
               if (b == ASCII_SPACE || (b >= ASCII_TAB && b <= ASCII_CR)) begin
                  // white space before the number is skipped
               end else if (b == ASCII_MINUS) begin
                  id_phase = ID_NEG;
               end else if (b == ASCII_PLUS) begin
                  id_phase = ID_DIGITS;
                  id_acc   = '0;
               end else if (is_digit(b)) begin
                  id_phase = ID_DIGITS;
                  id_acc   = 31'(b - ASCII_ZERO);
               end else begin
                  id_phase = ID_DONE;
               end
            end
            ID_DIGITS: begin
               if (is_digit(b)) begin
                  acc_next = longint'(id_acc) * 10 + longint'(b - ASCII_ZERO);
                  id_acc   = (acc_next > ID_MAX) ? ID_MAX : 31'(acc_next);
               end else begin
                  id_phase = ID_DONE;
               end
            end
            default: begin
            end
         endcase
      endfunction

      // field boundary: bad id check, record close or next field
      function void close_field(inout parse_result_type r);
         logic [2:0] last_pos;
         bit         id_field;
         last_pos = read_mode ? READ_LAST_FIELD : WRITE_LAST_FIELD;
         id_field = read_mode && field_pos >= ID_FIELD;
         r.field_end = 1'b1;
         if (id_field && (id_phase == ID_NEG || id_acc == '0)) begin
            halted = 1'b1;
            r.stop = 1'b1;
            return;
         end
         if (field_pos >= last_pos) begin
            r.param_id = read_mode ? id_acc : 31'({1'b0, rec_count} + 17'd1);
            if (rec_count != COUNT_MAX)
               rec_count = rec_count + 16'd1;
            r.record_end = 1'b1;
            field_pos    = '0;
         end else begin
            field_pos = field_pos + 3'd1;
         end
         id_acc   = '0;
         id_phase = ID_NONE;
      endfunction

      // predict the result of one accepted request
      function void note_request(bit first, logic [7:0] b);
         parse_result_type r;
         if (first)
            restart();
         r = '0;
         r.kind      = KIND_IGNORED;
         r.field_num = field_pos;
         if (!halted) begin
            if (!in_payload) begin
               if (!is_digit(b)) begin
                  halted = 1'b1;
                  r.stop = 1'b1;
               end else begin
                  r.kind      = KIND_LENGTH;
                  length_left = 10'(int'(length_left) * 10 + int'(b - ASCII_ZERO));
                  digits_seen = digits_seen + 2'd1;
                  if (digits_seen == HEADER_DIGITS) begin
                     digits_seen = '0;
                     if (length_left == '0)
                        close_field(r);
                     else
                        in_payload = 1'b1;
                  end
               end
            end else begin
               r.kind    = KIND_PAYLOAD;
               r.payload = b;
               if (read_mode && field_pos >= ID_FIELD)
                  take_id_byte(b);
               if (length_left != '0)
                  length_left = length_left - 10'd1;
               if (length_left == '0) begin
                  in_payload = 1'b0;
                  close_field(r);
               end
            end
         end
         r.count = rec_count;
         if (r.kind != KIND_IGNORED)
            parsed++;
         if (r.record_end)
            records++;
         if (r.stop)
            stops++;
         expected_results.push_back(r);
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      // compare one accepted result with the oldest prediction
      function void check_result(logic [63:0] data, logic [1:0] kind, logic last);
         parse_result_type e;
         if (expected_results.size() == 0) begin
            $display("%0t: result with no request outstanding, expected none actual %h",
                     $time, data);
            errors++;
            return;
         end
         e = expected_results.pop_front();
         checked++;
         check_field("byte_kind", e.kind, kind);
         check_field("payload_byte", e.payload, data[7:0]);
         check_field("field_number", e.field_num, data[10:8]);
         check_field("field_end", e.field_end, data[11]);
         check_field("stop_here", e.stop, data[12]);
         check_field("records_done", e.count, data[28:13]);
         check_field("parameter_id", e.param_id, data[59:29]);
         check_field("record_end", e.record_end, last);
      endfunction
   endclass

endpackage

module length_prefixed_record_parser_test;
   import lprp_pkg::*;
   import record_parse_check_pkg::*;

   // shapes of generated parameter id text
   typedef enum int {
      SHAPE_SPACED, SHAPE_PLUS, SHAPE_NEGATIVE, SHAPE_ZERO, SHAPE_HUGE,
      SHAPE_TRAILING, SHAPE_JUNK, SHAPE_EMPTY, SHAPE_PLAIN
   } id_shape_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] data_byte
   logic        req_tuser  = 1'b0; // [0] start_of_request
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [7:0] payload, [10:8] field, [11] field_end,
                                   // [12] stop, [28:13] records, [59:29] id
   logic [1:0]  rsp_tuser;         // [1:0] byte_kind
   logic        rsp_tlast;         // record_end

   record_parse_board board;
   logic [8:0]  byte_stream[$];    // {start, byte} waiting to be sent
   logic [7:0]  id_text[$];
   bit          mark_start;
   bit          mode_now = 1'b1;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_requests = 0;

   length_prefixed_record_parser dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off when one is asked for
   always @(posedge clock) begin : receiver
      int holds_served;
      int hold_left;
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left    = 80;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // stream building
   function automatic void put_byte(logic [7:0] b);
      byte_stream.push_back({mark_start, b});
      mark_start = 1'b0;
   endfunction

   function automatic void put_header(int len);
      put_byte(ASCII_ZERO + 8'(len / 100));
      put_byte(ASCII_ZERO + 8'((len / 10) % 10));
      put_byte(ASCII_ZERO + 8'(len % 10));
   endfunction

   function automatic void put_field(int len);
      put_header(len);
      repeat (len) put_byte(8'($urandom_range(255)));
   endfunction

   function automatic int rand_len();
      int k;
      k = $urandom_range(99);
      if (k < 70)
         return $urandom_range(0, 4);
      else if (k < 95)
         return $urandom_range(5, 20);
      return $urandom_range(21, 150);
   endfunction

   // decimal digits with a nonzero lead
   function automatic void add_digits(int n);
      id_text.push_back(ASCII_ZERO + 8'($urandom_range(1, 9)));
      repeat (n - 1) id_text.push_back(ASCII_ZERO + 8'($urandom_range(9)));
   endfunction

   // one whole record in the current mode, id text shaped at random
   function automatic void put_record(bit big);
      int           k;
      id_shape_type shape;
      for (int f = 0; f <= (mode_now ? READ_LAST_FIELD : WRITE_LAST_FIELD); f++) begin
         if (mode_now && f == ID_FIELD) begin
            id_text.delete();
            k = $urandom_range(12);
            shape = (k > SHAPE_PLAIN) ? SHAPE_PLAIN : id_shape_type'(k);
            case (shape)
               SHAPE_SPACED: begin
                  repeat ($urandom_range(1, 3)) begin
                     k = $urandom_range(5);
                     id_text.push_back(k == 5 ? ASCII_SPACE : ASCII_TAB + 8'(k));
                  end
                  add_digits($urandom_range(1, 4));
               end
               SHAPE_PLUS: begin
                  id_text.push_back(ASCII_PLUS);
                  add_digits($urandom_range(1, 4));
               end
               SHAPE_NEGATIVE: begin
                  id_text.push_back(ASCII_MINUS);
                  add_digits($urandom_range(1, 4));
               end
               SHAPE_ZERO: repeat ($urandom_range(1, 3)) id_text.push_back(ASCII_ZERO);
               SHAPE_HUGE: add_digits($urandom_range(10, 14));
               SHAPE_TRAILING: begin
                  add_digits($urandom_range(1, 3));
                  repeat ($urandom_range(1, 2)) id_text.push_back(8'($urandom_range(255)));
               end
               SHAPE_JUNK: id_text.push_back(8'($urandom_range(255)));
               SHAPE_EMPTY: begin
               end
               default: add_digits($urandom_range(1, 6));
            endcase
            put_header(id_text.size());
            foreach (id_text[i]) put_byte(id_text[i]);
         end else begin
            put_field((big && f == 0) ? 999 : rand_len());
         end
      end
   endfunction

   // one request: a few records, sometimes broken or cut short
   function automatic void build_request(bit first, bit big);
      int         n_records;
      logic [7:0] b;
      mark_start = first;
      n_records  = $urandom_range(1, 3);
      for (int r = 0; r < n_records; r++) begin
         if ($urandom_range(11) == 0) begin
            // good fields, maybe part of a header, then a non-digit, then ignored bytes
            repeat ($urandom_range(0, 4)) put_field(rand_len());
            repeat ($urandom_range(0, 2)) put_byte(ASCII_ZERO + 8'($urandom_range(9)));
            b = 8'($urandom_range(255));
            if (b >= ASCII_ZERO && b <= ASCII_NINE)
               b = b ^ 8'h80;
            put_byte(b);
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(255)));
            return;
         end
         put_record(big && r == 0);
      end
      // request ends inside a length header now and then
      if ($urandom_range(7) == 0)
         repeat ($urandom_range(1, 2)) put_byte(ASCII_ZERO + 8'($urandom_range(9)));
   endfunction

   // drive one request and wait for its handshake
   task automatic send_byte(input logic first, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(first, b);
   endtask

   task automatic send_stream();
      logic [8:0] v;
      while (byte_stream.size() != 0) begin
         v = byte_stream.pop_front();
         send_byte(v[8], v[7:0]);
      end
   endtask

   // sender goes quiet until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input bit m);
      csr_valid <= 1'b1;
      csr_data  <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid      <= 1'b0;
      board.read_mode = m;
      mode_now        = m;
   endtask

   // one stretch of random requests under one mode and one stall pattern
   task automatic run_phase(input bit mode, input int s_idle, input int r_idle,
                            input int target, input bit big, input bit pressure);
      bit first;
      drain();
      write_mode(mode);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      // first request may carry on the record left open by the last phase
      first = $urandom_range(1);
      if (pressure)
         hold_requests++;
      while (board.parsed < target) begin
         build_request(first, big);
         send_stream();
         if (pressure) begin
            drain();
            pressure = 1'b0;
         end
         first = ($urandom_range(9) != 0);
         big   = 1'b0;
      end
      // leave a record open so the next mode meets it midway
      mark_start = 1'b0;
      repeat ($urandom_range(1, 5)) put_field(rand_len());
      send_stream();
   endtask

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(1'b1);

      // directed: full read record with extreme payload bytes, stops, ignored bytes
      mark_start = 1'b1;
      put_header(2);
      put_byte(8'h00);
      put_byte(8'hFF);
      repeat (3) put_header(0);
      put_header(1);
      put_byte(ASCII_NINE);
      put_byte(ASCII_ZERO - 8'd1);   // bad header just below the digits
      put_byte(ASCII_NINE + 8'd1);   // ignored while stopped
      mark_start = 1'b1;
      put_byte(ASCII_NINE + 8'd1);   // bad header on the first byte of a request
      send_stream();

      // random phases
      run_phase(1'b0, 15, 79, 200, 1'b0, 1'b0);
      run_phase(1'b1, 79, 15, 400, 1'b0, 1'b0);
      run_phase(1'b0, 0, 0, 1400, 1'b1, 1'b1);
      run_phase(1'b1, 0, 0, 1500, 1'b0, 1'b0);

      drain();
      repeat (10) @(posedge clock);
      $display("sent %0d parsed bytes in both modes, checked %0d results: %0d records, %0d stops",
               board.parsed, board.checked, board.records, board.stops);
      if (board.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", board.pending());
      $display("== FAIL ==");
      $finish;
   end

endmodule
